// ===== rtl/bap_pkg.sv =====
// ----------------------------------------------------------------------------
// Blob aperture photometry package
// Shared widths, limits and control/status types for the photometry block.
// ----------------------------------------------------------------------------
package bap_pkg;

    // Input field widths
    localparam int PIX_W   = 16;   // pixel depth in bits
    localparam int OFS_W   = 8;
    localparam int SIZE_W  = 10;
    localparam int NOISE_W = 24;

    // Output field widths
    localparam int BASE_W = 24;
    localparam int PEAK_W = 25;
    localparam int FLUX_W = 41;
    localparam int PTF_W  = 24;
    localparam int SNR_W  = 32;

    // Accumulator widths
    localparam int SUM_W = 30;
    localparam int CNT_W = 15;

    // Geometry
    localparam int MAX_HALF_WINDOW = 127;
    localparam int WIN_W           = 11;   // compare width for the window bound
    localparam int SIZE_MIN        = 64;   // 4.0 in Q6.4
    localparam int D2_W            = 2 * OFS_W;
    localparam int QSQ_W           = 2 * SIZE_W;
    localparam int RAD_W           = QSQ_W + 4;   // 9 * size^2
    localparam int D2S_W           = D2_W + 10;   // 1024 * d2

    // Saturation limits
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [PIX_W-1:0] SAT_LEVEL_RESET = {PIX_W{1'b1}};

    // Shared divider
    localparam int DIV_NUM_W = 57;
    localparam int DIV_DEN_W = 41;
    localparam int DIV_CNT_W = 6;

    // Result clamps, held at quotient width
    localparam logic [DIV_NUM_W-1:0] QUO_MAX24   = DIV_NUM_W'(24'hFFFFFF);
    localparam logic [DIV_NUM_W-1:0] QUO_SNR_POS = DIV_NUM_W'(32'h7FFFFFFF);
    localparam logic [DIV_NUM_W-1:0] QUO_SNR_NEG = DIV_NUM_W'(33'h080000000);
    localparam logic [SNR_W-1:0]     SNR_MAX     = 32'h7FFFFFFF;
    localparam logic [SNR_W-1:0]     SNR_MIN     = 32'h80000000;

    // Stream payload widths
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 152;

    // Step strobes from the sequencer to the accumulator
    typedef struct packed {
        logic square;   // register squared offset and squared radius
        logic update;   // classify and accumulate the held pixel
        logic clear;    // start a new blob
    } bap_acc_ctl_t;

    // Running statistics of the current blob
    typedef struct packed {
        logic [SUM_W-1:0] core_sum;
        logic [CNT_W-1:0] core_count;
        logic [SUM_W-1:0] bg_sum;
        logic [CNT_W-1:0] bg_count;
        logic [PIX_W-1:0] peak;
        logic             sat_seen;
    } bap_stats_t;

endpackage

// ===== rtl/bap_accum.sv =====
// ----------------------------------------------------------------------------
// Blob aperture photometry accumulator
// Classifies one pixel as core or background and updates the blob statistics.
// ----------------------------------------------------------------------------
module bap_accum
    import bap_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  bap_acc_ctl_t            ctl,
    input  logic [PIX_W-1:0]        pixel,
    input  logic signed [OFS_W-1:0] offset_u,
    input  logic signed [OFS_W-1:0] offset_v,
    input  logic [SIZE_W-1:0]       blob_size_q4,
    input  logic [PIX_W-1:0]        saturation_level,
    output bap_stats_t              stats
);

    logic signed [WIN_W-1:0]  u_ext;
    logic signed [WIN_W-1:0]  v_ext;
    logic                     in_win;
    logic signed [D2_W-1:0]   sq_u;
    logic signed [D2_W-1:0]   sq_v;
    logic [SIZE_W-1:0]        size_m;
    logic [QSQ_W-1:0]         size_sq;
    logic [D2_W-1:0]          d2_next;
    logic [RAD_W-1:0]         rad_next;
    logic [D2_W-1:0]          d2_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic                     in_win_reg;
    logic                     is_core;
    logic [SUM_W:0]           core_add;
    logic [SUM_W:0]           bg_add;
    bap_stats_t               stats_reg;

    // Window bound and the two squared distances
    always_comb
    begin
        u_ext    = WIN_W'(offset_u);
        v_ext    = WIN_W'(offset_v);
        in_win   = (u_ext <= WIN_W'(MAX_HALF_WINDOW)) && (u_ext >= -WIN_W'(MAX_HALF_WINDOW)) &&
                   (v_ext <= WIN_W'(MAX_HALF_WINDOW)) && (v_ext >= -WIN_W'(MAX_HALF_WINDOW));
        sq_u     = D2_W'(offset_u) * D2_W'(offset_u);
        sq_v     = D2_W'(offset_v) * D2_W'(offset_v);
        d2_next  = $unsigned(sq_u) + $unsigned(sq_v);
        size_m   = (blob_size_q4 < SIZE_W'(SIZE_MIN)) ? SIZE_W'(SIZE_MIN) : blob_size_q4;
        size_sq  = QSQ_W'(size_m) * QSQ_W'(size_m);
        rad_next = RAD_W'({size_sq, 3'b000}) + RAD_W'(size_sq);
    end

    // First step: hold the squares
    always_ff @(posedge clk)
    begin
        if (ctl.square)
        begin
            d2_reg     <= d2_next;
            rad_reg    <= rad_next;
            in_win_reg <= in_win;
        end
    end

    // Core test and saturating sums
    always_comb
    begin
        is_core  = {d2_reg, 10'b0} < D2S_W'(rad_reg);
        core_add = (SUM_W+1)'(stats_reg.core_sum) + (SUM_W+1)'(pixel);
        bg_add   = (SUM_W+1)'(stats_reg.bg_sum) + (SUM_W+1)'(pixel);
    end

    // Second step: update the statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg <= '0;
        end
        else if (ctl.clear)
        begin
            stats_reg <= '0;
        end
        else if (ctl.update && in_win_reg)
        begin
            if (pixel >= saturation_level)
            begin
                stats_reg.sat_seen <= 1'b1;
            end
            if (pixel > stats_reg.peak)
            begin
                stats_reg.peak <= pixel;
            end
            if (is_core)
            begin
                stats_reg.core_sum <= (core_add > (SUM_W+1)'(SUM_MAX)) ?
                                      SUM_MAX : core_add[SUM_W-1:0];
                if (stats_reg.core_count != CNT_MAX)
                begin
                    stats_reg.core_count <= stats_reg.core_count + CNT_W'(1);
                end
            end
            else
            begin
                stats_reg.bg_sum <= (bg_add > (SUM_W+1)'(SUM_MAX)) ?
                                    SUM_MAX : bg_add[SUM_W-1:0];
                if (stats_reg.bg_count != CNT_MAX)
                begin
                    stats_reg.bg_count <= stats_reg.bg_count + CNT_W'(1);
                end
            end
        end
    end

    assign stats = stats_reg;

endmodule

// ===== rtl/bap_divider.sv =====
// ----------------------------------------------------------------------------
// Blob aperture photometry divider
// Unsigned restoring divider, one quotient bit per cycle, shared by all ratios.
// ----------------------------------------------------------------------------
module bap_divider
    import bap_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_NUM_W-1:0] quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // One shift-compare-subtract step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
        quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Step counter and completion strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/blob_aperture_photometry_top.sv =====
// ----------------------------------------------------------------------------
// Blob aperture photometry
// Core/annulus photometry of one star blob from a stream of window pixels.
// ----------------------------------------------------------------------------
// Usage:
// Pixels of a blob window arrive on the s_axis channel, one transfer per
// pixel, each with its signed offset from the blob center; s_axis_tlast marks
// the final pixel of the window. Each pixel passes through the accepting
// state, a state that forms the squared offset and radius, and one that
// accumulates; s_axis_tready is low in between. A last pixel is followed by
// the result phase, which runs up to three 57-step divisions on one shared
// divider (background mean, peak-to-flux ratio, SNR). The result waits in an
// output register; a stalled receiver holds it there and only blocks the
// block when the next result is ready to be written. cfg_wr_en writes the
// saturation level; write it only while the block is idle.
// Reset clears the statistics and drops m_axis_tvalid, and sets the
// saturation level to full scale.
// ----------------------------------------------------------------------------
module blob_aperture_photometry_top
    import bap_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration
    input  logic                  cfg_wr_en,
    input  logic [PIX_W-1:0]      cfg_wr_data,   // saturation_level
    // Pixel stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pixel[15:0], offset_u[23:16], offset_v[31:24], blob_size_q4[41:32],
    // noise_q8[65:42], zero[71:66]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // base_q8[23:0], peak_q8[48:24], flux_q8[89:49], peak_to_flux_q16[113:90],
    // snr_q16[145:114], saturated[146], zero[151:147]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int PTF_LSB  = BASE_W + PEAK_W + FLUX_W;
    localparam int FLUX_LSB = BASE_W + PEAK_W;
    localparam int PAD_W    = OUT_DATA_W - (PTF_LSB + PTF_W + SNR_W + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_UPDATE,
        S_BASE_GO,
        S_BASE_WAIT,
        S_FLUX,
        S_PTF_GO,
        S_PTF_WAIT,
        S_SNR_GO,
        S_SNR_WAIT,
        S_OUT
    } state_t;

    state_t                   state_reg;
    logic [PIX_W-1:0]         sat_level_reg;
    logic [PIX_W-1:0]         pix_reg;
    logic signed [OFS_W-1:0]  u_reg;
    logic signed [OFS_W-1:0]  v_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic [NOISE_W-1:0]       noise_reg;
    logic                     last_reg;
    logic [BASE_W-1:0]        base_reg;
    logic signed [PEAK_W-1:0] peak_reg;
    logic signed [FLUX_W-1:0] flux_reg;
    logic [PTF_W-1:0]         ptf_reg;
    logic [SNR_W-1:0]         snr_reg;
    logic                     m_valid_reg;
    logic [OUT_DATA_W-1:0]    m_data_reg;
    logic                     div_start_reg;
    logic [DIV_NUM_W-1:0]     div_num_reg;
    logic [DIV_DEN_W-1:0]     div_den_reg;
    logic                     div_busy;
    logic                     div_done;
    logic [DIV_NUM_W-1:0]     div_quo;
    bap_acc_ctl_t             acc_ctl;
    bap_stats_t               stats;
    logic                     s_xfer;
    logic                     out_free;
    logic [38:0]              base_prod;
    logic signed [FLUX_W-1:0] flux_next;
    logic signed [PEAK_W-1:0] peak_next;
    logic [FLUX_W-1:0]        flux_mag;

    // Handshake terms
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Accumulator step strobes
    always_comb
    begin
        acc_ctl.square = (state_reg == S_SQUARE);
        acc_ctl.update = (state_reg == S_UPDATE);
        acc_ctl.clear  = (state_reg == S_OUT) && out_free;
    end

    // Peak and flux against the background mean
    always_comb
    begin
        base_prod = 39'(base_reg) * 39'(stats.core_count);
        flux_next = $signed({3'b000, stats.core_sum, 8'h00}) - $signed({2'b00, base_prod});
        peak_next = $signed({1'b0, stats.peak, 8'h00}) - $signed({1'b0, base_reg});
        flux_mag  = flux_reg[FLUX_W-1] ? FLUX_W'(-flux_reg) : FLUX_W'(flux_reg);
    end

    // Saturation level register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_level_reg <= SAT_LEVEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            sat_level_reg <= cfg_wr_data;
        end
    end

    // Sequencer with its registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            div_start_reg <= 1'b0;
            div_num_reg   <= '0;
            div_den_reg   <= '0;
            pix_reg       <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            size_reg      <= '0;
            noise_reg     <= '0;
            last_reg      <= 1'b0;
            base_reg      <= '0;
            peak_reg      <= '0;
            flux_reg      <= '0;
            ptf_reg       <= '0;
            snr_reg       <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            // The output state reloads the register itself when it is free.
            if (m_valid_reg && m_axis_tready && state_reg != S_OUT)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_xfer)
                    begin
                        pix_reg   <= s_axis_tdata[15:0];
                        u_reg     <= s_axis_tdata[23:16];
                        v_reg     <= s_axis_tdata[31:24];
                        size_reg  <= s_axis_tdata[41:32];
                        noise_reg <= s_axis_tdata[65:42];
                        last_reg  <= s_axis_tlast;
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    state_reg <= last_reg ? S_BASE_GO : S_IDLE;
                end
                // Background mean, rounded half up
                S_BASE_GO:
                begin
                    if (stats.bg_count == '0)
                    begin
                        base_reg  <= '0;
                        state_reg <= S_FLUX;
                    end
                    else
                    begin
                        div_num_reg   <= DIV_NUM_W'({stats.bg_sum, 8'h00}) +
                                         DIV_NUM_W'(stats.bg_count >> 1);
                        div_den_reg   <= DIV_DEN_W'(stats.bg_count);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_BASE_WAIT;
                    end
                end
                S_BASE_WAIT:
                begin
                    if (div_done)
                    begin
                        base_reg  <= (div_quo > QUO_MAX24) ? {BASE_W{1'b1}} :
                                     div_quo[BASE_W-1:0];
                        state_reg <= S_FLUX;
                    end
                end
                S_FLUX:
                begin
                    flux_reg  <= flux_next;
                    peak_reg  <= peak_next;
                    state_reg <= S_PTF_GO;
                end
                // Peak over flux, only for a positive peak and flux
                S_PTF_GO:
                begin
                    if (flux_reg > 0 && peak_reg > 0)
                    begin
                        div_num_reg   <= DIV_NUM_W'({peak_reg[PEAK_W-2:0], 16'h0000}) +
                                         DIV_NUM_W'(flux_reg[FLUX_W-2:1]);
                        div_den_reg   <= DIV_DEN_W'(flux_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_PTF_WAIT;
                    end
                    else
                    begin
                        ptf_reg   <= '0;
                        state_reg <= S_SNR_GO;
                    end
                end
                S_PTF_WAIT:
                begin
                    if (div_done)
                    begin
                        ptf_reg   <= (div_quo > QUO_MAX24) ? {PTF_W{1'b1}} :
                                     div_quo[PTF_W-1:0];
                        state_reg <= S_SNR_GO;
                    end
                end
                // Flux over noise on the magnitude, sign applied afterwards
                S_SNR_GO:
                begin
                    if (noise_reg == '0)
                    begin
                        if (flux_reg > 0)
                        begin
                            snr_reg <= SNR_MAX;
                        end
                        else if (flux_reg < 0)
                        begin
                            snr_reg <= SNR_MIN;
                        end
                        else
                        begin
                            snr_reg <= '0;
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        div_num_reg   <= DIV_NUM_W'({flux_mag, 16'h0000}) +
                                         DIV_NUM_W'(noise_reg >> 1);
                        div_den_reg   <= DIV_DEN_W'(noise_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_SNR_WAIT;
                    end
                end
                S_SNR_WAIT:
                begin
                    if (div_done)
                    begin
                        if (flux_reg[FLUX_W-1])
                        begin
                            snr_reg <= (div_quo > QUO_SNR_NEG) ? SNR_MIN :
                                       SNR_W'(-div_quo[SNR_W-1:0]);
                        end
                        else
                        begin
                            snr_reg <= (div_quo > QUO_SNR_POS) ? SNR_MAX :
                                       div_quo[SNR_W-1:0];
                        end
                        state_reg <= S_OUT;
                    end
                end
                // Hand the result to the output register once it is free
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_data_reg  <= {{PAD_W{1'b0}}, stats.sat_seen, snr_reg, ptf_reg,
                                        flux_reg, peak_reg, base_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Pixel classification and statistics
    bap_accum u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (acc_ctl),
        .pixel            (pix_reg),
        .offset_u         (u_reg),
        .offset_v         (v_reg),
        .blob_size_q4     (size_reg),
        .saturation_level (sat_level_reg),
        .stats            (stats)
    );

    // Shared divider
    bap_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // The block takes no new pixel in the cycle after a pixel transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_axis_tready)
        else $error("pixel accepted while the previous one is in work");

    // The divider is never restarted while it is still iterating.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> !div_busy)
        else $error("divider started while busy");

    // A nonzero peak-to-flux ratio only comes with a positive flux.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[PTF_LSB+PTF_W-1:PTF_LSB] != '0) |->
        (!m_data_reg[FLUX_LSB+FLUX_W-1] && m_data_reg[FLUX_LSB+FLUX_W-1:FLUX_LSB] != '0))
        else $error("peak-to-flux ratio set without positive flux");

    // A result is never written over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("pending result overwritten");

endmodule

// ===== sim/tb_blob_aperture_photometry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob aperture photometry testbench
// Feeds blob windows of pixels through the photometry block under changing
// saturation levels and handshake pressure. Each result is checked field by
// field against photometry computed here from the pixels or typed in a directed row.
// ----------------------------------------------------------------------------
module tb_blob_aperture_photometry_top;
    import bap_pkg::*;

    localparam int STALL_LIMIT      = 10000;   // cycles without any transfer
    localparam int SETTLE_CYCLES    = 400;     // past one full result phase
    localparam int CFG_GUARD_CYCLES = 8;       // lets a non-last pixel finish
    localparam int HOLD_OFF_CYCLES  = 1500;
    localparam int PIXELS_PER_LEVEL = 125;
    localparam int FLOOD_PIXELS     = 60;      // two thirds core, one third sky
    localparam longint UNSIGNED24_MAX = 64'hFFFFFF;

    // One pixel transfer on the input stream
    typedef struct packed {
        logic [PIX_W-1:0]          pixel;
        logic signed [OFS_W-1:0]   offset_u;
        logic signed [OFS_W-1:0]   offset_v;
        logic [SIZE_W-1:0]         size_q4;
        logic [NOISE_W-1:0]        noise_q8;
        logic                      last;
    } pixel_item_t;

    // One photometry result on the output stream
    typedef struct packed {
        logic [BASE_W-1:0]         base_q8;
        logic signed [PEAK_W-1:0]  peak_q8;
        logic signed [FLUX_W-1:0]  flux_q8;
        logic [PTF_W-1:0]          peak_to_flux_q16;
        logic signed [SNR_W-1:0]   snr_q16;
        logic                      saturated;
    } photometry_t;

    typedef struct packed {
        pixel_item_t item;
        logic        typed;   // the result below is the expectation
        photometry_t want;
    } directed_row_t;

    // Directed windows; every group ends with a last pixel.
    localparam directed_row_t DIRECTED_ROWS [20] = '{
        // Right after reset: a last pixel outside the window yields all zeros.
        '{'{16'd100, 8'(-128), 8'sd0, 10'd0, 24'd256, 1'b1}, 1'b1,
          '{24'd0, 25'sd0, 41'sd0, 24'd0, 32'sd0, 1'b0}},
        // Lone full-scale core pixel, zero noise, reset saturation level.
        '{'{16'hFFFF, 8'sd0, 8'sd0, 10'd0, 24'd0, 1'b1}, 1'b1,
          '{24'd0, 25'sd16776960, 41'sd16776960, 24'd65536, SNR_MAX, 1'b1}},
        // Offset, size and noise extremes.
        '{'{16'd0, 8'sd127, 8'sd127, 10'd1023, 24'hFFFFFF, 1'b0}, 1'b0, '0},
        '{'{16'hFFFF, 8'(-127), 8'(-127), 10'd1023, 24'hFFFFFF, 1'b0}, 1'b0, '0},
        '{'{16'd1, 8'sd0, 8'(-1), 10'd64, 24'd0, 1'b0}, 1'b0, '0},
        '{'{16'd40000, 8'sd1, 8'sd0, 10'd1023, 24'hFFFFFF, 1'b1}, 1'b0, '0},
        // Bright sky around a dim core with a one-LSB noise: SNR clamps low.
        '{'{16'd60000, 8'sd50, 8'sd0, 10'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{16'd60000, 8'sd0, 8'(-50), 10'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{16'd10, 8'sd0, 8'sd0, 10'd0, 24'd1, 1'b1}, 1'b0, '0},
        // Negative flux with zero noise.
        '{'{16'd50000, 8'sd100, 8'sd0, 10'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{16'd0, 8'sd0, 8'sd0, 10'd0, 24'd0, 1'b1}, 1'b1,
          '{24'd12800000, 25'sd0, 41'(-12800000), 24'd0, SNR_MIN, 1'b0}},
        // Zero flux with zero noise.
        '{'{16'd1000, 8'sd127, 8'(-127), 10'd0, 24'd0, 1'b1}, 1'b1,
          '{24'd256000, 25'sd0, 41'sd0, 24'd0, 32'sd0, 1'b0}},
        // A saturated pixel outside the window must leave no trace.
        '{'{16'hFFFF, 8'sd0, 8'(-128), 10'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{16'd200, 8'sd3, 8'sd4, 10'd100, 24'd512, 1'b1}, 1'b0, '0},
        // Core radius edge at the minimum size and just above it.
        '{'{16'd300, 8'sd6, 8'sd0, 10'd0, 24'h123456, 1'b0}, 1'b0, '0},
        '{'{16'd500, 8'(-5), 8'sd3, 10'd63, 24'd0, 1'b0}, 1'b0, '0},
        '{'{16'd400, 8'sd0, 8'(-6), 10'd64, 24'd0, 1'b0}, 1'b0, '0},
        '{'{16'd700, 8'sd1, 8'sd1, 10'd65, 24'hABCDEF, 1'b1}, 1'b0, '0},
        // Dark sky, bright core, one-LSB noise: SNR clamps high.
        '{'{16'd0, 8'sd20, 8'sd20, 10'd0, 24'd0, 1'b0}, 1'b0, '0},
        '{'{16'hFFFF, 8'sd0, 8'sd0, 10'd0, 24'd1, 1'b1}, 1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [PIX_W-1:0]      cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Photometry state mirrored from the pixels sent so far
    logic [PIX_W-1:0] model_sat_level = SAT_LEVEL_RESET;
    bap_stats_t       blob_stats      = '0;
    photometry_t      pending_results[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;
    int pixels_sent    = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    blob_aperture_photometry_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Accumulates one pixel and, on the last one, forms the blob photometry.
    function automatic bit photometry_predict(input pixel_item_t it, output photometry_t res);
        int     du;
        int     dv;
        longint d2;
        longint q;
        longint sum;
        longint base;
        longint pk;
        longint flux;
        longint ratio;
        longint noise;
        longint mag;
        longint quo;
        du = it.offset_u;
        dv = it.offset_v;
        res = '0;
        if (du <= MAX_HALF_WINDOW && du >= -MAX_HALF_WINDOW &&
            dv <= MAX_HALF_WINDOW && dv >= -MAX_HALF_WINDOW)
        begin
            d2 = du * du + dv * dv;
            q = (it.size_q4 < SIZE_MIN) ? longint'(SIZE_MIN) : longint'(it.size_q4);
            if (it.pixel >= model_sat_level)
                blob_stats.sat_seen = 1'b1;
            if (it.pixel > blob_stats.peak)
                blob_stats.peak = it.pixel;
            // Core when 1024*d2 < 9*q*q, i.e. inside 1.5 blob sizes.
            if (1024 * d2 < 9 * q * q)
            begin
                sum = longint'(blob_stats.core_sum) + longint'(it.pixel);
                blob_stats.core_sum = (sum > longint'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum);
                if (blob_stats.core_count != CNT_MAX)
                    blob_stats.core_count++;
            end
            else
            begin
                sum = longint'(blob_stats.bg_sum) + longint'(it.pixel);
                blob_stats.bg_sum = (sum > longint'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum);
                if (blob_stats.bg_count != CNT_MAX)
                    blob_stats.bg_count++;
            end
        end
        if (!it.last)
            return 1'b0;

        // Background mean, rounded half up.
        base = 0;
        if (blob_stats.bg_count != 0)
        begin
            base = (longint'(blob_stats.bg_sum) * 256 + longint'(blob_stats.bg_count) / 2)
                   / longint'(blob_stats.bg_count);
            if (base > UNSIGNED24_MAX)
                base = UNSIGNED24_MAX;
        end
        pk = longint'(blob_stats.peak) * 256 - base;
        flux = longint'(blob_stats.core_sum) * 256 - base * longint'(blob_stats.core_count);

        ratio = 0;
        if (flux > 0 && pk > 0)
        begin
            ratio = (pk * 65536 + flux / 2) / flux;
            if (ratio > UNSIGNED24_MAX)
                ratio = UNSIGNED24_MAX;
        end

        // SNR rounds half away from zero and saturates to 32 bits.
        noise = it.noise_q8;
        if (noise == 0)
            res.snr_q16 = (flux > 0) ? SNR_MAX : ((flux < 0) ? SNR_MIN : '0);
        else
        begin
            mag = (flux < 0) ? -flux : flux;
            quo = (mag * 65536 + noise / 2) / noise;
            if (flux < 0)
                res.snr_q16 = (quo > 64'sd2147483648) ? SNR_MIN : SNR_W'(-quo);
            else
                res.snr_q16 = (quo > 64'sd2147483647) ? SNR_MAX : SNR_W'(quo);
        end

        res.base_q8          = BASE_W'(base);
        res.peak_q8          = PEAK_W'(pk);
        res.flux_q8          = FLUX_W'(flux);
        res.peak_to_flux_q16 = PTF_W'(ratio);
        res.saturated        = blob_stats.sat_seen;
        blob_stats = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("MISMATCH result %0d, %s: got %0d, expected %0d",
                 results_seen, field, got, want);
        mismatch_count++;
    endtask

    // Offers one pixel, with random idle cycles ahead of it, and waits for the transfer.
    task automatic send_pixel(input pixel_item_t it, input logic use_typed = 1'b0,
                              input photometry_t typed_res = '0);
        photometry_t res;
        logic        took;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({it.noise_q8, it.size_q4, it.offset_v,
                                     it.offset_u, it.pixel});
        s_axis_tlast  <= it.last;
        // Handshake is stable between edges, so it is sampled on the falling edge.
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
        end
        while (!took);
        if (photometry_predict(it, res))
            pending_results.insert(pending_results.size(), use_typed ? typed_res : res);
        @(posedge clk);
        pixels_sent++;
    endtask

    // Stops offering pixels until every pending result has been received.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_saturation_level(input logic [PIX_W-1:0] level);
        wait_for_results();
        repeat (CFG_GUARD_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_sat_level = level;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(posedge clk);
    endtask

    // Sends random blob windows until the pixel budget is spent.
    task automatic run_random(input int pixel_budget, input int len_cap);
        pixel_item_t      it;
        int               stop_at;
        int               len;
        int               half;
        int               pick;
        int               level;
        logic [SIZE_W-1:0] blob_size;
        logic [PIX_W-1:0]  sky;
        logic [NOISE_W-1:0] blob_noise;
        stop_at = pixels_sent + pixel_budget;
        while (pixels_sent < stop_at)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 10)
                len = 1;
            else if (pick < 80)
                len = $urandom_range(12, 2);
            else
                len = $urandom_range(40, 13);
            if (len > len_cap)
                len = len_cap;
            half = ($urandom_range(99, 0) < 70) ? $urandom_range(20, 1) : $urandom_range(127, 1);
            blob_size = ($urandom_range(99, 0) < 50) ? SIZE_W'($urandom) :
                                                        SIZE_W'($urandom_range(200, 0));
            pick = $urandom_range(99, 0);
            if (pick < 10)
                blob_noise = '0;
            else if (pick < 30)
                blob_noise = NOISE_W'($urandom_range(255, 1));
            else
                blob_noise = NOISE_W'($urandom);
            sky = PIX_W'($urandom_range(65535, 0) >> $urandom_range(15, 0));

            for (int i = 0; i < len; i++)
            begin
                it.offset_u = OFS_W'(int'($urandom_range(2 * half, 0)) - half);
                it.offset_v = OFS_W'(int'($urandom_range(2 * half, 0)) - half);
                // Occasional raw offsets, which may fall outside the window.
                if ($urandom_range(99, 0) < 5)
                    it.offset_u = OFS_W'($urandom);
                if ($urandom_range(99, 0) < 5)
                    it.offset_v = OFS_W'($urandom);
                it.size_q4 = ($urandom_range(99, 0) < 90) ? blob_size : SIZE_W'($urandom);
                pick = $urandom_range(99, 0);
                if (pick < 45)
                begin
                    level = int'(sky) + int'($urandom_range(255, 0));
                    it.pixel = (level > 65535) ? '1 : PIX_W'(level);
                end
                else if (pick < 95)
                    it.pixel = PIX_W'($urandom);
                else
                    it.pixel = '1;
                it.last = (i == len - 1);
                it.noise_q8 = it.last ? blob_noise : NOISE_W'($urandom);
                send_pixel(it);
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Checks each result transfer against the oldest pending result.
    always @(negedge clk)
    begin : result_monitor
        photometry_t got;
        photometry_t want;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.base_q8          = m_axis_tdata[23:0];
            got.peak_q8          = m_axis_tdata[48:24];
            got.flux_q8          = m_axis_tdata[89:49];
            got.peak_to_flux_q16 = m_axis_tdata[113:90];
            got.snr_q16          = m_axis_tdata[145:114];
            got.saturated        = m_axis_tdata[146];
            if (pending_results.size() == 0)
                report_mismatch("unexpected transfer, base_q8", got.base_q8, 0);
            else
            begin
                want = pending_results.pop_front();
                if (got.base_q8 !== want.base_q8)
                    report_mismatch("base_q8", got.base_q8, want.base_q8);
                if (got.peak_q8 !== want.peak_q8)
                    report_mismatch("peak_q8", got.peak_q8, want.peak_q8);
                if (got.flux_q8 !== want.flux_q8)
                    report_mismatch("flux_q8", got.flux_q8, want.flux_q8);
                if (got.peak_to_flux_q16 !== want.peak_to_flux_q16)
                    report_mismatch("peak_to_flux_q16", got.peak_to_flux_q16,
                                    want.peak_to_flux_q16);
                if (got.snr_q16 !== want.snr_q16)
                    report_mismatch("snr_q16", got.snr_q16, want.snr_q16);
                if (got.saturated !== want.saturated)
                    report_mismatch("saturated", got.saturated, want.saturated);
            end
            results_seen++;
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence
    initial
    begin : stimulus
        pixel_item_t flood;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles rarely, receiver often.
        set_idling(7, 82);
        for (int i = 0; i < 20; i++)
            send_pixel(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        write_saturation_level('0);
        run_random(PIXELS_PER_LEVEL, 40);
        write_saturation_level(PIX_W'($urandom));
        run_random(PIXELS_PER_LEVEL, 40);

        // Sender idles often, receiver rarely.
        set_idling(82, 7);
        write_saturation_level(SAT_LEVEL_RESET);
        run_random(PIXELS_PER_LEVEL, 40);
        write_saturation_level(PIX_W'($urandom_range(65535, 40000)));
        run_random(PIXELS_PER_LEVEL, 40);

        // No idling; first a long receiver hold-off against short windows.
        set_idling(0, 0);
        write_saturation_level(PIX_W'(1));
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        hold_left = HOLD_OFF_CYCLES;
        @(posedge clk);
        run_random(30, 2);
        run_random(PIXELS_PER_LEVEL, 40);

        // One long window of full-scale pixels, mostly core with some sky.
        write_saturation_level(SAT_LEVEL_RESET);
        for (int i = 0; i < FLOOD_PIXELS; i++)
        begin
            flood.pixel    = '1;
            flood.offset_u = (i % 3 == 2) ? 8'sd100 : 8'sd0;
            flood.offset_v = '0;
            flood.size_q4  = '0;
            flood.noise_q8 = 24'h000100;
            flood.last     = (i == FLOOD_PIXELS - 1);
            send_pixel(flood);
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
